// ===== sv/edist_pkg.sv =====
// ----------------------------------------------------------------------------
// Edit distance engine package
// Shared constants for the edit distance engine: action codes, the result
// width and the default string capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package edist_pkg;

    // Default capacity of each string in characters.
    localparam int MAX_LEN_DEF = 64;

    // Width of the distance result port.
    localparam int DIST_W = 7;

    // Width of the action field and its codes.
    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_APPEND_FIRST  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND_SECOND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE       = 2'd2;

    // Width of a character.
    localparam int CHAR_W = 8;

endpackage : edist_pkg

`default_nettype wire

// ===== sv/edit_distance_engine.sv =====
// ----------------------------------------------------------------------------
// Edit distance engine
// Loads two byte strings and computes their Levenshtein distance row by row
// over a single-port-pair score memory.
// ----------------------------------------------------------------------------
// How the block is used:
// An item is offered on action and char_byte with start high and is taken at
// a rising edge where busy is low. Actions 0 and 1 append char_byte to the
// first or the second string; busy stays low, so characters may be
// streamed one per cycle. Action 3 is ignored. Action 2 computes the distance
// between the kept strings, emits it on distance and truncated with done high
// for exactly one cycle, and then clears both lengths and the truncated flag.
// If either string is empty the result appears in the cycle after the item is
// taken and busy never rises. Otherwise busy is high while the sequencer
// preloads the score row and then, per row of the first string, fetches its
// character and steps one column per cycle through the score memory's
// read-modify-write path. The result is then strobed as busy falls, and the
// next item may be taken in that cycle.
// Characters beyond MAX_LEN are dropped and reported through truncated.
// The receiver cannot stall: done lasts one cycle whether or not it is used.
// Reset clears the lengths, the flag and the sequencer; the character and
// score memories hold no reset value, and only written entries are used.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance_engine
    import edist_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [CHAR_W-1:0] char_byte,
    output logic                   busy,
    output logic                   done,
    output logic [DIST_W-1:0]      distance,
    output logic                   truncated
);

    // A length runs from 0 to MAX_LEN; a text address from 0 to MAX_LEN-1.
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // Candidate sums may reach MAX_LEN + 1.
    localparam int SUM_W = LEN_W + 1;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] ONE      = LEN_W'(1);

    // Sequencer codes.
    localparam logic [1:0] ST_IDLE = 2'd0;  // taking items
    localparam logic [1:0] ST_INIT = 2'd1;  // preload score_row[j] = j
    localparam logic [1:0] ST_ROW  = 2'd2;  // fetch the row character
    localparam logic [1:0] ST_CELL = 2'd3;  // one column per cycle

    // Memories. Entry 0 of the score row is never stored: at the start of
    // row i it always holds i - 1, which the sequencer supplies itself.
    logic [CHAR_W-1:0] first_text  [MAX_LEN];
    logic [CHAR_W-1:0] second_text [MAX_LEN];
    logic [LEN_W-1:0]  score_row   [MAX_LEN + 1];

    logic [1:0]        state_reg, state_next;
    logic [LEN_W-1:0]  first_len_reg, first_len_next;
    logic [LEN_W-1:0]  second_len_reg, second_len_next;
    logic              overflow_reg, overflow_next;
    logic [LEN_W-1:0]  row_reg, row_next;        // current row i
    logic [LEN_W-1:0]  col_reg, col_next;        // column under work j
    logic [LEN_W-1:0]  left_reg, left_next;      // score_row[j-1] of this row
    logic [LEN_W-1:0]  diag_reg, diag_next;      // score_row[j-1] of last row
    logic              done_reg, done_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              trunc_reg, trunc_next;

    // Registered read data.
    logic [CHAR_W-1:0] row_char_q;
    logic [CHAR_W-1:0] col_char_q;
    logic [LEN_W-1:0]  above_q;

    // Memory ports.
    logic              first_we, second_we, score_we;
    logic [IDX_W-1:0]  first_wr_addr, second_wr_addr;
    logic [IDX_W-1:0]  first_rd_addr, second_rd_addr;
    logic [LEN_W-1:0]  score_wr_addr, score_rd_addr;
    logic [LEN_W-1:0]  score_wr_data;

    // Cell arithmetic.
    logic [SUM_W-1:0]  cand_above, cand_left, cand_diag, cand_min;
    logic [LEN_W-1:0]  cell_value;
    logic              take_item;

    assign take_item = start && (state_reg == ST_IDLE);

    always_comb
    begin
        cand_above = SUM_W'(above_q) + SUM_W'(1);
        cand_left  = SUM_W'(left_reg) + SUM_W'(1);
        cand_diag  = SUM_W'(diag_reg) + ((row_char_q == col_char_q) ? SUM_W'(0) : SUM_W'(1));
        cand_min   = cand_above;
        if (cand_left < cand_min)
        begin
            cand_min = cand_left;
        end
        if (cand_diag < cand_min)
        begin
            cand_min = cand_diag;
        end
        // A cell never exceeds MAX_LEN, so the narrow form is exact.
        cell_value = cand_min[LEN_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        overflow_next   = overflow_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        left_next       = left_reg;
        diag_next       = diag_reg;
        done_next       = 1'b0;
        dist_next       = dist_reg;
        trunc_next      = trunc_reg;

        first_we       = 1'b0;
        second_we      = 1'b0;
        score_we       = 1'b0;
        first_wr_addr  = first_len_reg[IDX_W-1:0];
        second_wr_addr = second_len_reg[IDX_W-1:0];
        first_rd_addr  = IDX_W'(row_reg - ONE);
        second_rd_addr = IDX_W'(col_reg);
        score_wr_addr  = col_reg;
        score_wr_data  = col_reg;
        score_rd_addr  = col_reg + ONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (take_item)
                begin
                    case (action)
                        ACT_APPEND_FIRST:
                        begin
                            if (first_len_reg < FULL_LEN)
                            begin
                                first_we       = 1'b1;
                                first_len_next = first_len_reg + ONE;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        ACT_APPEND_SECOND:
                        begin
                            if (second_len_reg < FULL_LEN)
                            begin
                                second_we       = 1'b1;
                                second_len_next = second_len_reg + ONE;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        ACT_COMPUTE:
                        begin
                            if ((first_len_reg == '0) || (second_len_reg == '0))
                            begin
                                // One side is empty: the distance is the other
                                // length, and the OR of the two gives it.
                                done_next       = 1'b1;
                                dist_next       = DIST_W'(first_len_reg | second_len_reg);
                                trunc_next      = overflow_reg;
                                first_len_next  = '0;
                                second_len_next = '0;
                                overflow_next   = 1'b0;
                            end
                            else
                            begin
                                state_next = ST_INIT;
                                row_next   = ONE;
                                col_next   = ONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                score_we      = 1'b1;
                score_wr_addr = col_reg;
                score_wr_data = col_reg;
                if (col_reg == second_len_reg)
                begin
                    state_next = ST_ROW;
                end
                else
                begin
                    col_next = col_reg + ONE;
                end
            end
            ST_ROW:
            begin
                // Fetch the row character and the first column's operands.
                first_rd_addr  = IDX_W'(row_reg - ONE);
                second_rd_addr = '0;
                score_rd_addr  = ONE;
                col_next       = ONE;
                left_next      = row_reg;
                diag_next      = row_reg - ONE;
                state_next     = ST_CELL;
            end
            ST_CELL:
            begin
                score_we       = 1'b1;
                score_wr_addr  = col_reg;
                score_wr_data  = cell_value;
                // Prefetch the next column while this one is written back.
                score_rd_addr  = col_reg + ONE;
                second_rd_addr = IDX_W'(col_reg);
                left_next      = cell_value;
                diag_next      = above_q;
                if (col_reg == second_len_reg)
                begin
                    if (row_reg == first_len_reg)
                    begin
                        state_next      = ST_IDLE;
                        done_next       = 1'b1;
                        dist_next       = DIST_W'(cell_value);
                        trunc_next      = overflow_reg;
                        first_len_next  = '0;
                        second_len_next = '0;
                        overflow_next   = 1'b0;
                    end
                    else
                    begin
                        row_next   = row_reg + ONE;
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    col_next = col_reg + ONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            overflow_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            overflow_reg   <= overflow_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        left_reg  <= left_next;
        diag_reg  <= diag_next;
        dist_reg  <= dist_next;
        trunc_reg <= trunc_next;
    end

    // First string memory.
    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_text[first_wr_addr] <= char_byte;
        end
        row_char_q <= first_text[first_rd_addr];
    end

    // Second string memory.
    always_ff @(posedge clk)
    begin
        if (second_we)
        begin
            second_text[second_wr_addr] <= char_byte;
        end
        col_char_q <= second_text[second_rd_addr];
    end

    // Score row memory. Within a row the write and the prefetch always hit
    // different columns, and the row fetch state separates successive rows.
    always_ff @(posedge clk)
    begin
        if (score_we)
        begin
            score_row[score_wr_addr] <= score_wr_data;
        end
        above_q <= score_row[score_rd_addr];
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign distance  = dist_reg;
    assign truncated = trunc_reg;

endmodule : edit_distance_engine

`default_nettype wire
